FILE: hw/rtl/slrg_pkg.sv
// shared types, constants and helper functions of the stepper ramp generator
package slrg_pkg;

    // ramp state codes as seen on the ramp_phase output
    typedef enum logic [2:0] {
        RS_IDLE   = 3'd0,
        RS_ACCEL  = 3'd1,
        RS_CRUISE = 3'd2,
        RS_DECEL  = 3'd3,
        RS_FINAL  = 3'd4
    } t_ramp;

    // sequencer states of the shared divider
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'd0,
        SEQ_DIV  = 2'd1,
        SEQ_SUB  = 2'd2,
        SEQ_RND  = 2'd3
    } t_seq;

    // operation codes of an input transaction
    typedef enum logic {
        OP_START = 1'b0,
        OP_TICK  = 1'b1
    } t_op;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_DELAY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET = 2'd2;

    // configuration reset values
    localparam logic [15:0] START_DELAY_RST  = 16'd50000;
    localparam logic [15:0] MIN_DELAY_RST    = 16'd2500;
    localparam logic [15:0] FIRST_OFFSET_RST = 16'd1000;

    // divider: 33-bit dividend, one quotient bit per cycle
    localparam int DIV_STEPS = 33;
    localparam int DIV_CNT_W = 6;

    // rounding offset for the 24.8 delay
    localparam logic [32:0] ROUND_HALF = 33'd128;

    // quadrature action word for each phase
    function automatic logic [15:0] phase_word(input logic [1:0] idx);
        logic [15:0] w;
        case (idx)
            2'd0:    w = 16'h0909;
            2'd1:    w = 16'h0908;
            2'd2:    w = 16'h0808;
            default: w = 16'h0809;
        endcase
        return w;
    endfunction

    // next quadrature phase in the given direction
    function automatic logic [1:0] phase_next(input logic [1:0] idx, input logic rev);
        return rev ? (idx - 2'd1) : (idx + 2'd1);
    endfunction

    // 4 * (step_counter - move_length) + add, kept in 20 bits
    function automatic logic [19:0] steps_left4(input logic [15:0] sc,
                                                input logic [15:0] len,
                                                input logic [2:0]  add);
        logic [19:0] diff;
        diff = {4'b0, sc} - {4'b0, len};
        return {diff[17:0], 2'b00} + {17'b0, add};
    endfunction

endpackage

FILE: hw/rtl/slrg_in_if.sv
// input channel: move start and step tick transactions
interface slrg_in_if;
    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [15:0] target_position;
    logic [15:0]        timer_now;

    modport source (output valid, output operation, output target_position,
                    output timer_now, input ready);
    modport sink   (input valid, input operation, input target_position,
                    input timer_now, output ready);
endinterface

FILE: hw/rtl/slrg_out_if.sv
// output channel: one result transaction per input transaction
interface slrg_out_if;
    logic               valid;
    logic               ready;
    logic               running;
    logic               outputs_updated;
    logic [15:0]        compare_value;
    logic [15:0]        phase_action;
    logic [15:0]        step_delay;
    logic signed [15:0] position;
    logic [2:0]         ramp_phase;

    modport source (output valid, output running, output outputs_updated,
                    output compare_value, output phase_action, output step_delay,
                    output position, output ramp_phase, input ready);
    modport sink   (input valid, input running, input outputs_updated,
                    input compare_value, input phase_action, input step_delay,
                    input position, input ramp_phase, output ready);
endinterface

FILE: hw/rtl/stepper_linear_ramp_generator.sv
// linear ramp stepper profile generator with a shared bit-serial divider
// result: start, idle tick and ticks without a delay update give a result in the cycle after accept
// result: ticks that update the delay give a result only after the sequencer has run through
//   the one-bit-per-cycle restoring divider (SEQ_DIV), then the subtract and round states
// throughput: one transaction at a time, next accepted once the result is taken or leaving
// reset: synchronous active-low, clears the sequencer and ramp state to idle and loads the register defaults
module stepper_linear_ramp_generator (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [slrg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [15:0]                      i_cfg_data,
    slrg_in_if.sink                          i_in,
    slrg_out_if.source                       o_out
);

    // configuration registers
    logic [15:0] r_start_dly, r_min_dly, r_first_ofs;

    // sequencer and result handshake
    slrg_pkg::t_seq  r_seq, n_seq;
    logic            r_out_valid, n_out_valid;
    logic            r_updated, n_updated;

    // ramp state
    slrg_pkg::t_ramp r_ramp, n_ramp;
    logic [15:0]     r_pos, n_pos;
    logic            r_rev, n_rev;
    logic [1:0]      r_phase, n_phase;
    logic [15:0]     r_cmp, n_cmp;
    logic [15:0]     r_dly_int, n_dly_int;
    logic [31:0]     r_dly_fix, n_dly_fix;
    logic [15:0]     r_sc, n_sc;
    logic [15:0]     r_decel, n_decel;
    logic [15:0]     r_len, n_len;
    logic [15:0]     r_mid, n_mid;
    logic [19:0]     r_den, n_den;
    logic            r_run, n_run;

    // divider datapath
    logic [19:0]                     r_div_rem, n_div_rem;
    logic [32:0]                     r_div_quo, n_div_quo;
    logic [19:0]                     r_div_mag, n_div_mag;
    logic                            r_div_neg, n_div_neg;
    logic                            r_div_zero, n_div_zero;
    logic [slrg_pkg::DIV_CNT_W-1:0]  r_div_cnt, n_div_cnt;
    logic [15:0]                     r_decel_cand, n_decel_cand;

    logic in_ready;
    logic accept;

    // handshake
    assign in_ready   = (r_seq == slrg_pkg::SEQ_IDLE) && (!r_out_valid || o_out.ready);
    assign accept     = i_in.valid && in_ready;
    assign i_in.ready = in_ready;

    // result fields come from the state registers, phase_action through the phase_word decode
    assign o_out.valid           = r_out_valid;
    assign o_out.running         = r_run;
    assign o_out.outputs_updated = r_updated;
    assign o_out.compare_value   = r_cmp;
    assign o_out.phase_action    = slrg_pkg::phase_word(r_phase);
    assign o_out.step_delay      = r_dly_int;
    assign o_out.position        = r_pos;
    assign o_out.ramp_phase      = r_ramp;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_dly <= slrg_pkg::START_DELAY_RST;
            r_min_dly   <= slrg_pkg::MIN_DELAY_RST;
            r_first_ofs <= slrg_pkg::FIRST_OFFSET_RST;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                slrg_pkg::CFG_START_DELAY:  r_start_dly <= i_cfg_data;
                slrg_pkg::CFG_MIN_DELAY:    r_min_dly   <= i_cfg_data;
                slrg_pkg::CFG_FIRST_OFFSET: r_first_ofs <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq       <= slrg_pkg::SEQ_IDLE;
            r_out_valid <= 1'b0;
            r_updated   <= 1'b0;
            r_ramp      <= slrg_pkg::RS_IDLE;
            r_pos       <= '0;
            r_rev       <= 1'b0;
            r_phase     <= '0;
            r_cmp       <= '0;
            r_dly_int   <= '0;
            r_dly_fix   <= '0;
            r_sc        <= '0;
            r_decel     <= '0;
            r_len       <= '0;
            r_mid       <= '0;
            r_den       <= '0;
            r_run       <= 1'b0;
            r_div_cnt   <= '0;
        end else begin
            r_seq       <= n_seq;
            r_out_valid <= n_out_valid;
            r_updated   <= n_updated;
            r_ramp      <= n_ramp;
            r_pos       <= n_pos;
            r_rev       <= n_rev;
            r_phase     <= n_phase;
            r_cmp       <= n_cmp;
            r_dly_int   <= n_dly_int;
            r_dly_fix   <= n_dly_fix;
            r_sc        <= n_sc;
            r_decel     <= n_decel;
            r_len       <= n_len;
            r_mid       <= n_mid;
            r_den       <= n_den;
            r_run       <= n_run;
            r_div_cnt   <= n_div_cnt;
        end
    end

    // divider payload registers
    always_ff @(posedge i_clk) begin
        r_div_rem    <= n_div_rem;
        r_div_quo    <= n_div_quo;
        r_div_mag    <= n_div_mag;
        r_div_neg    <= n_div_neg;
        r_div_zero   <= n_div_zero;
        r_decel_cand <= n_decel_cand;
    end

    // next state: transaction decode, ramp machine and divider sequencing
    always_comb begin
        slrg_pkg::t_ramp nr;
        logic [19:0]     nd;
        logic            do_upd;
        logic            last_exit;
        logic [15:0]     len_new;
        logic            rev_new;
        logic [20:0]     rem_sh;
        logic            qbit;
        logic [31:0]     q32;
        logic [32:0]     rnd_sum;
        logic [24:0]     rnd;
        logic [15:0]     sat;

        n_seq        = r_seq;
        n_out_valid  = r_out_valid && !o_out.ready;
        n_updated    = r_updated;
        n_ramp       = r_ramp;
        n_pos        = r_pos;
        n_rev        = r_rev;
        n_phase      = r_phase;
        n_cmp        = r_cmp;
        n_dly_int    = r_dly_int;
        n_dly_fix    = r_dly_fix;
        n_sc         = r_sc;
        n_decel      = r_decel;
        n_len        = r_len;
        n_mid        = r_mid;
        n_den        = r_den;
        n_run        = r_run;
        n_div_rem    = r_div_rem;
        n_div_quo    = r_div_quo;
        n_div_mag    = r_div_mag;
        n_div_neg    = r_div_neg;
        n_div_zero   = r_div_zero;
        n_div_cnt    = r_div_cnt;
        n_decel_cand = r_decel_cand;

        nr        = r_ramp;
        nd        = r_den;
        do_upd    = 1'b0;
        last_exit = 1'b0;
        len_new   = '0;
        rev_new   = 1'b0;
        rem_sh    = '0;
        qbit      = 1'b0;
        q32       = '0;
        rnd_sum   = '0;
        rnd       = '0;
        sat       = '0;

        case (r_seq)
            slrg_pkg::SEQ_IDLE: begin
                if (accept) begin
                    if (i_in.operation == slrg_pkg::OP_START) begin
                        // start: direction and length toward the target
                        if (i_in.target_position != $signed(r_pos)) begin
                            if (i_in.target_position < $signed(r_pos)) begin
                                len_new = r_pos - i_in.target_position;
                                rev_new = 1'b1;
                            end else begin
                                len_new = i_in.target_position - r_pos;
                                rev_new = 1'b0;
                            end
                            n_len     = len_new;
                            n_rev     = rev_new;
                            n_mid     = (len_new - 16'd1) >> 1;
                            n_dly_int = r_start_dly;
                            n_dly_fix = {8'b0, r_start_dly, 8'b0};
                            n_sc      = '0;
                            n_den     = 20'd1;
                            n_ramp    = slrg_pkg::RS_ACCEL;
                            n_run     = 1'b1;
                            n_cmp     = i_in.timer_now + r_first_ofs;
                            n_phase   = slrg_pkg::phase_next(r_phase, rev_new);
                            n_updated = 1'b1;
                        end else begin
                            n_updated = 1'b0;
                        end
                        n_out_valid = 1'b1;
                    end else if (r_ramp == slrg_pkg::RS_IDLE) begin
                        // tick while idle is ignored
                        n_updated   = 1'b0;
                        n_out_valid = 1'b1;
                    end else begin
                        n_cmp = r_cmp + r_dly_int;
                        // ramp state machine for this step
                        case (r_ramp)
                            slrg_pkg::RS_ACCEL: begin
                                if (r_sc == r_mid && !r_len[0]) begin
                                    nr = slrg_pkg::RS_DECEL;
                                    nd = slrg_pkg::steps_left4(r_sc, r_len, 3'd1) + 20'd4;
                                end else begin
                                    if (r_sc == r_mid) begin
                                        nr = slrg_pkg::RS_DECEL;
                                        nd = slrg_pkg::steps_left4(r_sc, r_len, 3'd1);
                                    end
                                    if (r_sc == r_len - 16'd1) begin
                                        nr = slrg_pkg::RS_FINAL;
                                    end else begin
                                        do_upd = 1'b1;
                                    end
                                end
                            end
                            slrg_pkg::RS_DECEL: begin
                                if (r_sc == r_len - 16'd1) begin
                                    nr = slrg_pkg::RS_FINAL;
                                end else begin
                                    do_upd = 1'b1;
                                end
                            end
                            slrg_pkg::RS_CRUISE: begin
                                if (r_sc == r_decel) begin
                                    nr = slrg_pkg::RS_DECEL;
                                    nd = slrg_pkg::steps_left4(r_sc, r_len, 3'd5);
                                end
                            end
                            default: begin
                                last_exit = 1'b1;
                            end
                        endcase

                        if (last_exit) begin
                            // last tick: compare advanced, move ends
                            n_ramp      = slrg_pkg::RS_IDLE;
                            n_run       = 1'b0;
                            n_updated   = 1'b0;
                            n_out_valid = 1'b1;
                        end else begin
                            n_ramp    = nr;
                            n_pos     = r_rev ? (r_pos - 16'd1) : (r_pos + 16'd1);
                            n_sc      = r_sc + 16'd1;
                            n_updated = 1'b1;
                            if (nr != slrg_pkg::RS_FINAL) begin
                                n_phase = slrg_pkg::phase_next(r_phase, r_rev);
                            end
                            if (do_upd) begin
                                // delay update: launch the divider
                                nd           = nd + 20'd4;
                                n_decel_cand = r_len - r_sc;
                                n_div_neg    = nd[19];
                                n_div_mag    = nd[19] ? (20'd0 - nd) : nd;
                                n_div_zero   = (nd == '0);
                                n_div_quo    = {r_dly_fix, 1'b0};
                                n_div_rem    = '0;
                                n_div_cnt    = '0;
                                n_seq        = slrg_pkg::SEQ_DIV;
                            end else begin
                                n_out_valid = 1'b1;
                            end
                            n_den = nd;
                        end
                    end
                end
            end

            slrg_pkg::SEQ_DIV: begin
                // one restoring division step
                rem_sh = {r_div_rem, r_div_quo[32]};
                if (rem_sh >= {1'b0, r_div_mag}) begin
                    qbit      = 1'b1;
                    n_div_rem = 20'(rem_sh - {1'b0, r_div_mag});
                end else begin
                    qbit      = 1'b0;
                    n_div_rem = rem_sh[19:0];
                end
                n_div_quo = {r_div_quo[31:0], qbit};
                n_div_cnt = r_div_cnt + slrg_pkg::DIV_CNT_W'(1);
                if (r_div_cnt == slrg_pkg::DIV_CNT_W'(slrg_pkg::DIV_STEPS - 1)) begin
                    n_seq = slrg_pkg::SEQ_SUB;
                end
            end

            slrg_pkg::SEQ_SUB: begin
                // signed quotient subtracted from the fixed-point delay
                q32 = r_div_neg ? (32'd0 - r_div_quo[31:0]) : r_div_quo[31:0];
                if (!r_div_zero) begin
                    n_dly_fix = r_dly_fix - q32;
                end
                n_seq = slrg_pkg::SEQ_RND;
            end

            slrg_pkg::SEQ_RND: begin
                // round, saturate and clamp at the minimum delay
                rnd_sum = {1'b0, r_dly_fix} + slrg_pkg::ROUND_HALF;
                rnd     = rnd_sum[32:8];
                sat     = (|rnd[24:16]) ? 16'hFFFF : rnd[15:0];
                if (sat <= r_min_dly) begin
                    n_ramp    = slrg_pkg::RS_CRUISE;
                    n_decel   = r_decel_cand;
                    n_dly_int = r_min_dly;
                end else begin
                    n_dly_int = sat;
                end
                n_out_valid = 1'b1;
                n_seq       = slrg_pkg::SEQ_IDLE;
            end

            default: begin
                n_seq = slrg_pkg::SEQ_IDLE;
            end
        endcase
    end

endmodule

FILE: verif/tb_stepper_linear_ramp_generator.sv
// self-checking testbench of the stepper linear ramp generator: moves, ticks and register settings
module tb_stepper_linear_ramp_generator;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 40;
    localparam int DRAIN_CYCLES  = 50;

    // one result transaction as seen on the output channel
    typedef struct packed {
        logic        running;
        logic        updated;
        logic [15:0] compare;
        logic [15:0] action;
        logic [15:0] delay;
        logic [15:0] position;
        logic [2:0]  phase;
    } t_ramp_report;

    // tracks the ramp profile and checks each result against it
    class t_scoreboard;
        logic [15:0]     start_delay;
        logic [15:0]     min_delay;
        logic [15:0]     first_offset;
        slrg_pkg::t_ramp ramp;
        logic [15:0]     pos;
        logic            rev;
        logic [1:0]      quad;
        logic [15:0]     cmp_acc;
        logic [15:0]     dly_int;
        logic [31:0]     dly_fx;
        logic [15:0]     step_cnt;
        logic [15:0]     decel_at;
        logic [15:0]     len;
        logic [15:0]     mid;
        int              denom;
        logic            running;
        t_ramp_report    due_reports[$];
        int              n_in;
        int              n_checked;
        int              n_mismatch;
        int              n_unexpected;
        int              n_saturated;
        int              n_starts;
        int              n_restarts;
        int              n_idle_ticks;

        function new();
            start_delay  = slrg_pkg::START_DELAY_RST;
            min_delay    = slrg_pkg::MIN_DELAY_RST;
            first_offset = slrg_pkg::FIRST_OFFSET_RST;
            ramp         = slrg_pkg::RS_IDLE;
            pos          = '0;
            rev          = 1'b0;
            quad         = '0;
            cmp_acc      = '0;
            dly_int      = '0;
            dly_fx       = '0;
            step_cnt     = '0;
            decel_at     = '0;
            len          = '0;
            mid          = '0;
            denom        = 0;
            running      = 1'b0;
            n_in         = 0;
            n_checked    = 0;
            n_mismatch   = 0;
            n_unexpected = 0;
            n_saturated  = 0;
            n_starts     = 0;
            n_restarts   = 0;
            n_idle_ticks = 0;
        endfunction

        function void set_reg(logic [slrg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
            case (idx)
                slrg_pkg::CFG_START_DELAY:  start_delay  = value;
                slrg_pkg::CFG_MIN_DELAY:    min_delay    = value;
                slrg_pkg::CFG_FIRST_OFFSET: first_offset = value;
                default: ;
            endcase
        endfunction

        // 20-bit two's complement wrap
        function int wrap20(longint x);
            logic [19:0] v;
            v = x[19:0];
            return int'($signed(v));
        endfunction

        function logic [15:0] quad_word(logic [1:0] idx);
            case (idx)
                2'd0:    return 16'h0909;
                2'd1:    return 16'h0908;
                2'd2:    return 16'h0808;
                default: return 16'h0809;
            endcase
        endfunction

        function void step_quad();
            quad = rev ? quad - 2'd1 : quad + 2'd1;
        endfunction

        function int steps_left4(int add);
            return wrap20((longint'(step_cnt) - longint'(len)) * 4 + add);
        endfunction

        // d -= 2d/denom in 24.8, round, saturate, clamp at the plateau
        function void update_delay();
            longint q;
            longint r;
            denom = wrap20(longint'(denom) + 4);
            if (denom != 0) begin
                q      = (longint'(dly_fx) * 2) / longint'(denom);
                dly_fx = dly_fx - q[31:0];
            end
            r = (longint'(dly_fx) + 128) >>> 8;
            if (r > 65535) begin
                r = 65535;
                n_saturated++;
            end
            dly_int = r[15:0];
            if (dly_int <= min_delay) begin
                ramp     = slrg_pkg::RS_CRUISE;
                decel_at = len - step_cnt;
                dly_int  = min_delay;
            end
        endfunction

        // start of a move: direction, length and first delay
        function bit begin_move(logic [15:0] target);
            logic signed [15:0] t;
            logic signed [15:0] p;
            t = target;
            p = pos;
            if (t < p) begin
                len = pos - target;
                rev = 1'b1;
            end else if (t != p) begin
                len = target - pos;
                rev = 1'b0;
            end else begin
                return 1'b0;
            end
            if (running)
                n_restarts++;
            mid      = (len - 16'd1) >> 1;
            dly_int  = start_delay;
            dly_fx   = {8'd0, start_delay, 8'd0};
            step_cnt = '0;
            denom    = 1;
            ramp     = slrg_pkg::RS_ACCEL;
            running  = 1'b1;
            cmp_acc  = '0;
            return 1'b1;
        endfunction

        // one compare match: advance compare, run the ramp machine, take a step
        function bit step_tick();
            bit held;
            held = 1'b0;
            if (ramp == slrg_pkg::RS_IDLE)
                return 1'b0;
            cmp_acc = cmp_acc + dly_int;
            case (ramp)
                slrg_pkg::RS_ACCEL: begin
                    if (step_cnt == mid) begin
                        ramp  = slrg_pkg::RS_DECEL;
                        denom = steps_left4(1);
                        if (!len[0]) begin
                            denom = wrap20(longint'(denom) + 4);
                            held  = 1'b1;
                        end
                    end
                    if (!held) begin
                        if (step_cnt == len - 16'd1)
                            ramp = slrg_pkg::RS_FINAL;
                        else
                            update_delay();
                    end
                end
                slrg_pkg::RS_DECEL: begin
                    if (step_cnt == len - 16'd1)
                        ramp = slrg_pkg::RS_FINAL;
                    else
                        update_delay();
                end
                slrg_pkg::RS_CRUISE: begin
                    if (step_cnt == decel_at) begin
                        ramp  = slrg_pkg::RS_DECEL;
                        denom = steps_left4(5);
                    end
                end
                default: begin
                    ramp    = slrg_pkg::RS_IDLE;
                    running = 1'b0;
                    return 1'b0;
                end
            endcase
            pos      = pos + (rev ? 16'hFFFF : 16'h0001);
            step_cnt = step_cnt + 16'd1;
            // the last tick repeats the phase
            if (ramp != slrg_pkg::RS_FINAL)
                step_quad();
            return 1'b1;
        endfunction

        function void note_input(slrg_pkg::t_op op, logic [15:0] target, logic [15:0] now);
            bit           upd;
            t_ramp_report r;
            n_in++;
            if (op == slrg_pkg::OP_START) begin
                upd = begin_move(target);
                if (upd) begin
                    cmp_acc = now + first_offset;
                    step_quad();
                    n_starts++;
                end
            end else begin
                if (ramp == slrg_pkg::RS_IDLE)
                    n_idle_ticks++;
                upd = step_tick();
            end
            r.running  = running;
            r.updated  = upd;
            r.compare  = cmp_acc;
            r.action   = quad_word(quad);
            r.delay    = dly_int;
            r.position = pos;
            r.phase    = ramp;
            due_reports.push_back(r);
        endfunction

        function string report_text(t_ramp_report r);
            return $sformatf("run=%0b upd=%0b cmp=%04h act=%04h dly=%0d pos=%0d ramp=%0d",
                             r.running, r.updated, r.compare, r.action, r.delay,
                             $signed(r.position), r.phase);
        endfunction

        function void check_result(t_ramp_report got);
            t_ramp_report want;
            if (due_reports.size() == 0) begin
                n_unexpected++;
                if (n_unexpected + n_mismatch <= 10)
                    $display("unexpected result: %s", report_text(got));
                return;
            end
            want = due_reports.pop_front();
            n_checked++;
            if (got.running !== want.running || got.updated !== want.updated ||
                got.compare !== want.compare || got.action !== want.action ||
                got.delay !== want.delay || got.position !== want.position ||
                got.phase !== want.phase) begin
                n_mismatch++;
                if (n_unexpected + n_mismatch <= 10) begin
                    $display("mismatch on result %0d: expected %s", n_checked, report_text(want));
                    $display("mismatch on result %0d: actual   %s", n_checked, report_text(got));
                end
            end
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           cfg_wr_en;
    logic [slrg_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                    cfg_data;
    logic [15:0]                    ready_pattern = 16'hFFFF;
    logic [3:0]                     ready_idx = '0;
    int                             gap_max = 0;
    int                             burst_left = 0;
    int                             n_settings = 0;
    int                             idle_cycles;
    t_scoreboard                    sb = new();

    slrg_in_if  in_ch ();
    slrg_out_if out_ch ();

    stepper_linear_ramp_generator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // clock
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver stalls follow a rotating 16-bit pattern
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(negedge clk);
            out_ch.ready <= ready_pattern[ready_idx];
            ready_idx = ready_idx + 4'd1;
        end
    end

    // result monitor
    always @(posedge clk) begin
        t_ramp_report got;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.running  = out_ch.running;
            got.updated  = out_ch.outputs_updated;
            got.compare  = out_ch.compare_value;
            got.action   = out_ch.phase_action;
            got.delay    = out_ch.step_delay;
            got.position = out_ch.position;
            got.phase    = out_ch.ramp_phase;
            sb.check_result(got);
        end
    end

    // watchdog on cycles without any transaction
    initial begin
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic idle_gap(int n);
        if (n > 0) begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // one input transaction, with burst gaps in front
    task automatic send_item(slrg_pkg::t_op op, logic [15:0] target, logic [15:0] now);
        if (burst_left == 0) begin
            if (gap_max > 0)
                idle_gap($urandom_range(0, gap_max));
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        @(negedge clk);
        in_ch.valid           <= 1'b1;
        in_ch.operation       <= op;
        in_ch.target_position <= target;
        in_ch.timer_now       <= now;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        sb.note_input(op, target, now);
    endtask

    task automatic send_tick();
        send_item(slrg_pkg::OP_TICK, 16'($urandom), 16'($urandom));
    endtask

    // start a move and tick it until idle or until the tick budget runs out
    task automatic run_move(logic [15:0] target, logic [15:0] now, int max_ticks);
        int cap;
        int n;
        send_item(slrg_pkg::OP_START, target, now);
        cap = (sb.len > 16'd40) ? 40 : 2 * int'(sb.len) + 4;
        if (max_ticks >= 0)
            cap = max_ticks;
        n = 0;
        while (sb.ramp != slrg_pkg::RS_IDLE && n < cap) begin
            send_tick();
            n++;
        end
    endtask

    // hold the sender until every result is back
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sb.due_reports.size() != 0) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic cfg_write(logic [slrg_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        sb.set_reg(idx, value);
    endtask

    // idle the block, then load all three registers
    task automatic apply_setting(logic [15:0] s, logic [15:0] m, logic [15:0] o);
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_write(slrg_pkg::CFG_START_DELAY, s);
        cfg_write(slrg_pkg::CFG_MIN_DELAY, m);
        cfg_write(slrg_pkg::CFG_FIRST_OFFSET, o);
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // random moves, restarts and noise under one register setting
    task automatic run_phase(logic [15:0] s, logic [15:0] m, logic [15:0] o, int gaps,
                             logic [15:0] pattern, int n);
        int          goal;
        int          drain_at;
        int          r;
        int          hop;
        logic [15:0] target;
        apply_setting(s, m, o);
        gap_max       = gaps;
        ready_pattern = pattern;
        goal          = sb.n_in + n;
        drain_at      = sb.n_in + $urandom_range(5, n - 5);
        while (sb.n_in < goal) begin
            if (sb.n_in >= drain_at) begin
                drain();
                drain_at = goal + 1;
            end
            r = $urandom_range(0, 99);
            if (r < 5) begin
                send_tick();
            end else if (r < 10) begin
                run_move(sb.pos, 16'($urandom), -1);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 80)
                    hop = $urandom_range(1, 24);
                else if (r < 95)
                    hop = $urandom_range(25, 80);
                else
                    hop = $urandom;
                if ($urandom_range(0, 1))
                    hop = -hop;
                target = sb.pos + hop[15:0];
                // some moves are cut short by the next start
                run_move(target, 16'($urandom),
                         ($urandom_range(0, 99) < 15) ? int'($urandom_range(0, 8)) : -1);
            end
        end
    endtask

    // main sequence
    initial begin
        int s;
        int m;
        int failures;
        rst_n                 <= 1'b0;
        cfg_wr_en             <= 1'b0;
        cfg_index             <= slrg_pkg::CFG_START_DELAY;
        cfg_data              <= '0;
        in_ch.valid           <= 1'b0;
        in_ch.operation       <= slrg_pkg::OP_START;
        in_ch.target_position <= '0;
        in_ch.timer_now       <= '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part under reset register values
        ready_pattern = 16'hF7DF;
        gap_max       = 2;
        send_item(slrg_pkg::OP_TICK, 16'h8000, 16'hFFFF);
        send_item(slrg_pkg::OP_START, 16'h0000, 16'h0000);
        run_move(16'h0001, 16'hFFFF, -1);
        run_move(sb.pos + 16'd2, 16'h0000, -1);
        run_move(sb.pos + 16'd3, 16'($urandom), -1);
        run_move(16'h8000, 16'($urandom), 2);
        run_move(16'h7FFF, 16'($urandom), 1);
        run_move(sb.pos - 16'd1, 16'($urandom), -1);

        // extreme settings, then random ones, then back to the defaults
        run_phase(16'd65535, 16'd1, 16'd65535, 0, 16'hFFFF, 60);
        run_phase(16'd1, 16'd65535, 16'd1, 4, 16'($urandom_range(1, 65535)), 50);
        run_phase(16'd1000, 16'd500, 16'($urandom_range(1, 65535)), 6,
                  16'($urandom_range(1, 65535)), 60);
        for (int k = 0; k < 4; k++) begin
            s = $urandom_range(200, 65535);
            m = s * $urandom_range(30, 98) / 100;
            run_phase(s[15:0], m[15:0], 16'($urandom_range(1, 65535)), $urandom_range(0, 8),
                      (k == 0) ? 16'hFFFF : 16'($urandom_range(1, 65535)), 75);
        end
        run_phase(slrg_pkg::START_DELAY_RST, slrg_pkg::MIN_DELAY_RST,
                  slrg_pkg::FIRST_OFFSET_RST, 3, 16'($urandom_range(1, 65535)), 60);

        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        failures = sb.n_mismatch + sb.n_unexpected + sb.due_reports.size();
        if (sb.due_reports.size() != 0)
            $display("%0d results never arrived", sb.due_reports.size());
        $display("summary: %0d transactions under %0d register settings, %0d results checked",
                 sb.n_in, n_settings, sb.n_checked);
        $display("summary: %0d moves, %0d restarts, %0d idle ticks, %0d delay saturations",
                 sb.n_starts, sb.n_restarts, sb.n_idle_ticks, sb.n_saturated);
        if (failures == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/slrg_pkg.sv
hw/rtl/slrg_in_if.sv
hw/rtl/slrg_out_if.sv
hw/rtl/stepper_linear_ramp_generator.sv
verif/tb_stepper_linear_ramp_generator.sv
